[rtl/core/lrupc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrupc_pkg
// Shared types and constants of the prefer-clean true-LRU replacement core.
// ----------------------------------------------------------------------------
package lrupc_pkg;

    localparam int SETS_DEF   = 64;
    localparam int WAYS_DEF   = 8;

    localparam int SET_IDX_W  = 6;
    localparam int HIT_WAY_W  = 3;
    localparam int DIRTY_W    = 8;
    localparam int VICTIM_W   = 3;

    // Number of distinct set indexes the request field can carry.
    localparam int SET_SPAN   = 1 << SET_IDX_W;

    // Request kinds.
    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Status from the row logic to the sequencer.
    typedef struct packed {
        logic                touch;
        logic [VICTIM_W-1:0] victim;
    } lrupc_calc_t;

endpackage
`default_nettype wire

[rtl/core/lrupc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrupc_req_if / lrupc_rsp_if
// Valid/ready channels carrying requests into and victims out of the core.
// ----------------------------------------------------------------------------
interface lrupc_req_if;
    import lrupc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [SET_IDX_W-1:0] set_index;
    logic                 hit_found;
    logic [HIT_WAY_W-1:0] hit_way;
    logic [DIRTY_W-1:0]   dirty_mask;

    modport source (
        output valid, req_type, set_index, hit_found, hit_way, dirty_mask,
        input  ready
    );

    modport sink (
        input  valid, req_type, set_index, hit_found, hit_way, dirty_mask,
        output ready
    );
endinterface

interface lrupc_rsp_if;
    import lrupc_pkg::*;

    logic                valid;
    logic                ready;
    logic [VICTIM_W-1:0] victim_way;

    modport source (
        output valid, victim_way,
        input  ready
    );

    modport sink (
        input  valid, victim_way,
        output ready
    );
endinterface
`default_nettype wire

[rtl/core/lrupc_row_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrupc_row_mem
// Recency-list memory, one row per set, with a registered read and a valid
// bit per row so that a row never written reads as the reset order.
// ----------------------------------------------------------------------------
module lrupc_row_mem
    import lrupc_pkg::*;
#(
    parameter int ROWS = SETS_DEF,
    parameter int WAYS = WAYS_DEF,
    localparam int AW  = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int WW  = $clog2(WAYS),
    localparam int RW  = WAYS * WW
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [RW-1:0] rd_row,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [RW-1:0] wr_row
);

    logic [RW-1:0]   row_store_reg [ROWS];
    logic [ROWS-1:0] row_valid_reg;
    logic [RW-1:0]   rd_data_reg;
    logic            rd_valid_reg;
    logic [RW-1:0]   init_row;

    // Reset order: position j holds way j.
    always_comb
    begin
        for (int j = 0; j < WAYS; j++)
        begin
            init_row[j*WW +: WW] = WW'(j);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_store_reg[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_store_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : init_row;

endmodule
`default_nettype wire

[rtl/core/lrupc_row_logic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrupc_row_logic
// Modify stage: moves the hit way to the front of the row and picks the
// eviction victim from the same row.
// ----------------------------------------------------------------------------
module lrupc_row_logic
    import lrupc_pkg::*;
#(
    parameter int WAYS = WAYS_DEF,
    localparam int WW  = $clog2(WAYS),
    localparam int RW  = WAYS * WW
)
(
    input  wire logic [RW-1:0]        row,
    input  wire logic [HIT_WAY_W-1:0] hit_way,
    input  wire logic [DIRTY_W-1:0]   dirty_mask,
    input  wire logic                 prefer_clean,
    output logic      [RW-1:0]        new_row,
    output lrupc_calc_t               calc
);

    // One bit above the wider of the two way fields, so that WAYS itself fits.
    localparam int CW = ((WW > HIT_WAY_W) ? WW : HIT_WAY_W) + 1;
    localparam int DX = 1 << WW;

    logic [WAYS-1:0] match;
    logic [WAYS-1:0] shift_pos;
    logic [DX-1:0]   dirty_ext;
    logic [WW-1:0]   pick;
    logic            way_ok;

    assign way_ok = CW'(hit_way) < CW'(WAYS);

    // Positions at or ahead of the hit position shift back by one.
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            match[i] = CW'(row[i*WW +: WW]) == CW'(hit_way);
        end
        shift_pos[WAYS-1] = match[WAYS-1];
        for (int i = WAYS - 2; i >= 0; i--)
        begin
            shift_pos[i] = shift_pos[i+1] | match[i];
        end
        new_row = row;
        new_row[0 +: WW] = WW'(hit_way);
        for (int i = 1; i < WAYS; i++)
        begin
            if (shift_pos[i])
            begin
                new_row[i*WW +: WW] = row[(i-1)*WW +: WW];
            end
        end
    end

    // Dirty bits exist only for ways below the mask width.
    always_comb
    begin
        for (int w = 0; w < DX; w++)
        begin
            dirty_ext[w] = (w < DIRTY_W) ? dirty_mask[w % DIRTY_W] : 1'b0;
        end
    end

    // The least recent clean position wins under prefer_clean; the oldest way is the fallback.
    always_comb
    begin
        pick = row[(WAYS-1)*WW +: WW];
        if (prefer_clean)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                if (!dirty_ext[row[i*WW +: WW]])
                begin
                    pick = row[i*WW +: WW];
                end
            end
        end
    end

    assign calc.touch  = way_ok & shift_pos[0];
    assign calc.victim = VICTIM_W'(pick);

endmodule
`default_nettype wire

[rtl/core/lru_prefer_clean_replacement_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lru_prefer_clean_replacement_core
// True-LRU recency lists for a set-associative cache with an optional
// prefer-clean eviction choice.
// ----------------------------------------------------------------------------
// In the cycle a request is accepted the set's row is read from the row
// memory, and in the next cycle the row logic either writes the updated
// order back (access hit) or loads the victim into the output register
// (query). Because of this read then write of one row per request, no new
// request is taken until the current one has left ST_EXEC. A query whose
// victim finds the output register still occupied waits in ST_EXEC until
// the result is taken; requests are
// accepted while an earlier result is pending. The set index is reduced
// modulo SETS, accesses naming a way at or above WAYS are ignored, and a
// query never changes the order. No clearing pass is needed after reset:
// each row has a valid bit, and an unwritten row reads as way j at position
// j. The prefer_clean register is written through cfg_wr_en/cfg_wr_data.
// ----------------------------------------------------------------------------
module lru_prefer_clean_replacement_core
    import lrupc_pkg::*;
#(
    parameter int SETS = SETS_DEF,
    parameter int WAYS = WAYS_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data,
    lrupc_req_if.sink   req,
    lrupc_rsp_if.source rsp
);

    // Only set indexes the request field can name need a row.
    localparam int ROWS = (SETS < SET_SPAN) ? SETS : SET_SPAN;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WW   = $clog2(WAYS);
    localparam int RW   = WAYS * WW;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg, state_next;
    logic                prefer_clean_reg;
    logic                out_valid_reg, out_valid_next;
    logic [VICTIM_W-1:0] victim_reg, victim_next;

    // Request captured at acceptance, used in the modify cycle.
    logic                 req_type_reg;
    logic                 hit_found_reg;
    logic [HIT_WAY_W-1:0] hit_way_reg;
    logic [DIRTY_W-1:0]   dirty_mask_reg;
    logic [AW-1:0]        set_addr_reg;

    logic                 accept;
    logic [SET_IDX_W-1:0] set_mod;
    logic [AW-1:0]        set_addr;
    logic [RW-1:0]        cur_row;
    logic [RW-1:0]        new_row;
    logic                 wr_en;
    lrupc_calc_t          calc;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid & req.ready;

    // Set index modulo SETS by restoring subtraction of shifted copies of
    // SETS; only shifts that stay inside the index range take part.
    always_comb
    begin
        set_mod = req.set_index;
        for (int k = SET_IDX_W - 1; k >= 0; k--)
        begin
            if ((SETS << k) < SET_SPAN)
            begin
                if (set_mod >= SET_IDX_W'(SETS << k))
                begin
                    set_mod = set_mod - SET_IDX_W'(SETS << k);
                end
            end
        end
    end

    assign set_addr = AW'(set_mod);

    lrupc_row_mem #(
        .ROWS (ROWS),
        .WAYS (WAYS)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (set_addr),
        .rd_row  (cur_row),
        .wr_en   (wr_en),
        .wr_addr (set_addr_reg),
        .wr_row  (new_row)
    );

    lrupc_row_logic #(
        .WAYS (WAYS)
    ) u_row_logic (
        .row          (cur_row),
        .hit_way      (hit_way_reg),
        .dirty_mask   (dirty_mask_reg),
        .prefer_clean (prefer_clean_reg),
        .new_row      (new_row),
        .calc         (calc)
    );

    // The write-back happens in the modify cycle; the next read of any row is
    // only accepted once the state is back in ST_IDLE, so no forwarding is needed.
    assign wr_en = (state_reg == ST_EXEC) && (req_type_reg == REQ_ACCESS)
                   && hit_found_reg && calc.touch;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        victim_next    = victim_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (req_type_reg == REQ_ACCESS)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    victim_next    = calc.victim;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            prefer_clean_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                prefer_clean_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        victim_reg <= victim_next;
        if (accept)
        begin
            req_type_reg   <= req.req_type;
            hit_found_reg  <= req.hit_found;
            hit_way_reg    <= req.hit_way;
            dirty_mask_reg <= req.dirty_mask;
            set_addr_reg   <= set_addr;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.victim_way = victim_reg;

endmodule
`default_nettype wire
